FILE: src/sss_pkg.sv
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types, codes and defaults of the scoped symbol stack.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_KEY_BITS    = 16;
    localparam int DEF_HANDLE_BITS = 16;
    localparam int DEF_LEVEL_BITS  = 8;

    typedef enum logic [1:0] {
        OP_ENTER   = 2'd0,
        OP_EXIT    = 2'd1,
        OP_DECLARE = 2'd2,
        OP_LOOKUP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_SATURATED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_RESULT
    } state_t;

    // per-cycle commands broadcast to every cell of the row
    typedef struct packed {
        logic shift_down;   // push: each cell takes its newer neighbor
        logic shift_up;     // pop: each cell takes its older neighbor
        logic scan;         // advance the lookup chain one cell
    } cell_ctrl_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] name_key;
        logic [15:0] decl_handle;
        logic [4:0]  decl_form;
        logic [31:0] form_mask;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [15:0] match_handle;
        logic [1:0]  status;
        logic [7:0]  current_level;
    } rsp_t;

endpackage

FILE: src/sss_req_if.sv
// ----------------------------------------------------------------------------
// sss_req_if
// Request channel: valid/ready handshake carrying one command beat.
// ----------------------------------------------------------------------------
interface sss_req_if;
    import sss_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/sss_rsp_if.sv
// ----------------------------------------------------------------------------
// sss_rsp_if
// Response channel: valid/ready handshake carrying one result beat.
// ----------------------------------------------------------------------------
interface sss_rsp_if;
    import sss_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/scoped_symbol_stack.sv
// Results: enter, declare and refused items load their result beat on
// acceptance; exit pops entries out of the cell row one at a time in S_POP,
// then loads its beat; lookup runs the match chain in S_SCAN, one cell per
// cycle toward the newest entry, then loads its beat in S_RESULT.
// Throughput: one item at a time, taken when idle and no result beat waits.
// Reset: asynchronous, clears the cell valid bits, scope level and control.
// ----------------------------------------------------------------------------
// scoped_symbol_stack
// Declaration stack for nested scopes with enter, exit, declare and lookup.
// ----------------------------------------------------------------------------
module scoped_symbol_stack #(
    parameter int STACK_DEPTH = sss_pkg::DEF_STACK_DEPTH,
    parameter int KEY_BITS    = sss_pkg::DEF_KEY_BITS,
    parameter int HANDLE_BITS = sss_pkg::DEF_HANDLE_BITS,
    parameter int LEVEL_BITS  = sss_pkg::DEF_LEVEL_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    sss_req_if.sink   req,
    sss_rsp_if.source rsp
);
    import sss_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH);

    state_t                 state_reg, state_next;
    logic [LEVEL_BITS-1:0]  depth_reg, depth_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [KEY_BITS-1:0]    key_reg;
    logic [31:0]            mask_reg;
    logic                   rsp_valid_reg;
    rsp_t                   rsp_reg, rsp_next;
    logic                   rsp_load;
    logic                   latch_en;
    cell_ctrl_t             ctrl;

    logic                   req_fire;
    op_t                    op;
    logic                   pop_hit;
    logic                   saturated;
    logic [KEY_BITS-1:0]    in_key;
    logic                   top_valid;
    logic [LEVEL_BITS-1:0]  top_level;
    logic                   full;
    logic                   scan_found;
    logic [HANDLE_BITS-1:0] scan_handle;

    assign req.ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign req_fire  = req.valid && req.ready;
    assign op        = op_t'(req.data.operation);
    assign in_key    = KEY_BITS'(req.data.name_key);
    assign saturated = (depth_reg == {LEVEL_BITS{1'b1}});
    // entry levels never decrease toward cell 0, so pops stop at the first
    // entry that is not deeper than the new level
    assign pop_hit   = top_valid && (top_level > depth_reg);

    sss_row #(
        .STACK_DEPTH (STACK_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .HANDLE_BITS (HANDLE_BITS),
        .LEVEL_BITS  (LEVEL_BITS)
    ) u_row (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .push_name   (in_key),
        .push_handle (HANDLE_BITS'(req.data.decl_handle)),
        .push_form   (req.data.decl_form),
        .push_level  (depth_reg),
        .scan_key    (key_reg),
        .scan_mask   (mask_reg),
        .top_valid   (top_valid),
        .top_level   (top_level),
        .full        (full),
        .scan_found  (scan_found),
        .scan_handle (scan_handle)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (op == OP_LOOKUP)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (op == OP_EXIT && depth_reg != '0)
                    begin
                        state_next = S_POP;
                    end
                end
            end
            S_POP:
            begin
                if (!pop_hit)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg == CNT_W'(STACK_DEPTH - 1))
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl          = '0;
        depth_next    = depth_reg;
        cnt_next      = cnt_reg;
        latch_en      = 1'b0;
        rsp_load      = 1'b0;
        rsp_next      = '0;
        rsp_next.status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    case (op)
                        OP_ENTER:
                        begin
                            rsp_load = 1'b1;
                            if (saturated)
                            begin
                                rsp_next.status = ST_SATURATED;
                            end
                            else
                            begin
                                depth_next = depth_reg + 1'b1;
                            end
                        end
                        OP_EXIT:
                        begin
                            if (depth_reg == '0)
                            begin
                                rsp_load        = 1'b1;
                                rsp_next.status = ST_UNDERFLOW;
                            end
                            else
                            begin
                                depth_next = depth_reg - 1'b1;
                            end
                        end
                        OP_DECLARE:
                        begin
                            rsp_load = 1'b1;
                            if (full)
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                ctrl.shift_down = 1'b1;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            latch_en = 1'b1;
                            cnt_next = '0;
                        end
                        default:
                        begin
                            rsp_load = 1'b0;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                if (pop_hit)
                begin
                    ctrl.shift_up = 1'b1;
                end
                else
                begin
                    rsp_load = 1'b1;
                end
            end
            S_SCAN:
            begin
                ctrl.scan = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
            end
            S_RESULT:
            begin
                rsp_load              = 1'b1;
                rsp_next.found        = scan_found;
                rsp_next.match_handle = 16'(scan_handle);
            end
            default:
            begin
                rsp_load = 1'b0;
            end
        endcase
        rsp_next.current_level = 8'(depth_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            cnt_reg   <= cnt_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (latch_en)
        begin
            key_reg  <= in_key;
            mask_reg <= req.data.form_mask;
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

endmodule

FILE: src/sss_cell.sv
// ----------------------------------------------------------------------------
// sss_cell
// One stack slot: holds an entry, shifts with its neighbors and forwards
// the lookup chain toward the newest slot.
// ----------------------------------------------------------------------------
module sss_cell #(
    parameter int KEY_BITS    = sss_pkg::DEF_KEY_BITS,
    parameter int HANDLE_BITS = sss_pkg::DEF_HANDLE_BITS,
    parameter int LEVEL_BITS  = sss_pkg::DEF_LEVEL_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sss_pkg::cell_ctrl_t    ctrl,
    // newer neighbor (source on push)
    input  logic                   up_valid,
    input  logic [KEY_BITS-1:0]    up_name,
    input  logic [HANDLE_BITS-1:0] up_handle,
    input  logic [4:0]             up_form,
    input  logic [LEVEL_BITS-1:0]  up_level,
    // older neighbor (source on pop)
    input  logic                   dn_valid,
    input  logic [KEY_BITS-1:0]    dn_name,
    input  logic [HANDLE_BITS-1:0] dn_handle,
    input  logic [4:0]             dn_form,
    input  logic [LEVEL_BITS-1:0]  dn_level,
    // lookup chain
    input  logic [KEY_BITS-1:0]    scan_key,
    input  logic [31:0]            scan_mask,
    input  logic                   scan_found_in,
    input  logic [HANDLE_BITS-1:0] scan_handle_in,
    output logic                   scan_found,
    output logic [HANDLE_BITS-1:0] scan_handle,
    // held entry
    output logic                   valid,
    output logic [KEY_BITS-1:0]    name,
    output logic [HANDLE_BITS-1:0] handle,
    output logic [4:0]             form,
    output logic [LEVEL_BITS-1:0]  level
);
    import sss_pkg::*;

    logic                   valid_reg;
    logic [KEY_BITS-1:0]    name_reg;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [4:0]             form_reg;
    logic [LEVEL_BITS-1:0]  level_reg;
    logic                   found_reg;
    logic [HANDLE_BITS-1:0] match_reg;
    logic                   hit;

    assign hit = valid_reg && (name_reg == scan_key) && scan_mask[form_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.shift_down)
        begin
            valid_reg <= up_valid;
        end
        else if (ctrl.shift_up)
        begin
            valid_reg <= dn_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift_down)
        begin
            name_reg   <= up_name;
            handle_reg <= up_handle;
            form_reg   <= up_form;
            level_reg  <= up_level;
        end
        else if (ctrl.shift_up)
        begin
            name_reg   <= dn_name;
            handle_reg <= dn_handle;
            form_reg   <= dn_form;
            level_reg  <= dn_level;
        end
    end

    // a hit here overrides anything older coming up the chain
    always_ff @(posedge clk)
    begin
        if (ctrl.scan)
        begin
            found_reg <= hit || scan_found_in;
            match_reg <= hit ? handle_reg : scan_handle_in;
        end
    end

    assign scan_found  = found_reg;
    assign scan_handle = match_reg;
    assign valid       = valid_reg;
    assign name        = name_reg;
    assign handle      = handle_reg;
    assign form        = form_reg;
    assign level       = level_reg;

endmodule

FILE: src/sss_row.sv
// ----------------------------------------------------------------------------
// sss_row
// Row of stack cells, newest entry in cell 0. Wires each cell to its
// neighbors for push, pop and the lookup chain.
// ----------------------------------------------------------------------------
module sss_row #(
    parameter int STACK_DEPTH = sss_pkg::DEF_STACK_DEPTH,
    parameter int KEY_BITS    = sss_pkg::DEF_KEY_BITS,
    parameter int HANDLE_BITS = sss_pkg::DEF_HANDLE_BITS,
    parameter int LEVEL_BITS  = sss_pkg::DEF_LEVEL_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sss_pkg::cell_ctrl_t    ctrl,
    input  logic [KEY_BITS-1:0]    push_name,
    input  logic [HANDLE_BITS-1:0] push_handle,
    input  logic [4:0]             push_form,
    input  logic [LEVEL_BITS-1:0]  push_level,
    input  logic [KEY_BITS-1:0]    scan_key,
    input  logic [31:0]            scan_mask,
    output logic                   top_valid,
    output logic [LEVEL_BITS-1:0]  top_level,
    output logic                   full,
    output logic                   scan_found,
    output logic [HANDLE_BITS-1:0] scan_handle
);
    import sss_pkg::*;

    logic                   valid_a  [STACK_DEPTH];
    logic [KEY_BITS-1:0]    name_a   [STACK_DEPTH];
    logic [HANDLE_BITS-1:0] handle_a [STACK_DEPTH];
    logic [4:0]             form_a   [STACK_DEPTH];
    logic [LEVEL_BITS-1:0]  level_a  [STACK_DEPTH];
    logic                   sfound_a [STACK_DEPTH];
    logic [HANDLE_BITS-1:0] shandle_a[STACK_DEPTH];

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic                   up_valid;
        logic [KEY_BITS-1:0]    up_name;
        logic [HANDLE_BITS-1:0] up_handle;
        logic [4:0]             up_form;
        logic [LEVEL_BITS-1:0]  up_level;
        logic                   dn_valid;
        logic [KEY_BITS-1:0]    dn_name;
        logic [HANDLE_BITS-1:0] dn_handle;
        logic [4:0]             dn_form;
        logic [LEVEL_BITS-1:0]  dn_level;
        logic                   sin_found;
        logic [HANDLE_BITS-1:0] sin_handle;

        if (i == 0)
        begin : g_head
            assign up_valid  = 1'b1;
            assign up_name   = push_name;
            assign up_handle = push_handle;
            assign up_form   = push_form;
            assign up_level  = push_level;
        end
        else
        begin : g_mid_up
            assign up_valid  = valid_a[i-1];
            assign up_name   = name_a[i-1];
            assign up_handle = handle_a[i-1];
            assign up_form   = form_a[i-1];
            assign up_level  = level_a[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_tail
            assign dn_valid   = 1'b0;
            assign dn_name    = '0;
            assign dn_handle  = '0;
            assign dn_form    = '0;
            assign dn_level   = '0;
            assign sin_found  = 1'b0;
            assign sin_handle = '0;
        end
        else
        begin : g_mid_dn
            assign dn_valid   = valid_a[i+1];
            assign dn_name    = name_a[i+1];
            assign dn_handle  = handle_a[i+1];
            assign dn_form    = form_a[i+1];
            assign dn_level   = level_a[i+1];
            assign sin_found  = sfound_a[i+1];
            assign sin_handle = shandle_a[i+1];
        end

        sss_cell #(
            .KEY_BITS    (KEY_BITS),
            .HANDLE_BITS (HANDLE_BITS),
            .LEVEL_BITS  (LEVEL_BITS)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctrl           (ctrl),
            .up_valid       (up_valid),
            .up_name        (up_name),
            .up_handle      (up_handle),
            .up_form        (up_form),
            .up_level       (up_level),
            .dn_valid       (dn_valid),
            .dn_name        (dn_name),
            .dn_handle      (dn_handle),
            .dn_form        (dn_form),
            .dn_level       (dn_level),
            .scan_key       (scan_key),
            .scan_mask      (scan_mask),
            .scan_found_in  (sin_found),
            .scan_handle_in (sin_handle),
            .scan_found     (sfound_a[i]),
            .scan_handle    (shandle_a[i]),
            .valid          (valid_a[i]),
            .name           (name_a[i]),
            .handle         (handle_a[i]),
            .form           (form_a[i]),
            .level          (level_a[i])
        );
    end

    assign top_valid   = valid_a[0];
    assign top_level   = level_a[0];
    // valid bits stay contiguous from cell 0, so the last cell marks full
    assign full        = valid_a[STACK_DEPTH-1];
    assign scan_found  = sfound_a[0];
    assign scan_handle = shandle_a[0];

endmodule

FILE: bench/tb_scoped_symbol_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scoped_symbol_stack
// Drives enter/exit/declare/lookup beats into the scoped symbol stack. A short
// table of directed beats comes first, then random episodes: mixed traffic,
// stack fills past full, and one climb to the top scope level and back down.
// A shadow symbol table predicts each result beat not given by a typed
// directed row, checked per field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_scoped_symbol_stack;
    import sss_pkg::*;

    localparam int STACK       = DEF_STACK_DEPTH;
    localparam int TOP_LEVEL   = (1 << DEF_LEVEL_BITS) - 1;
    localparam int RANDOM_BEATS = 950;
    localparam int N_DIRECTED  = 22;

    typedef struct packed {
        op_t         op;
        logic [15:0] key;
        logic [15:0] handle;
        logic [4:0]  form;
        logic [31:0] mask;
        logic        typed;
        rsp_t        want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    sss_req_if req_ch ();
    sss_rsp_if rsp_ch ();

    scoped_symbol_stack dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow symbol table
    logic [15:0] sym_key    [STACK];
    logic [15:0] sym_handle [STACK];
    logic [4:0]  sym_form   [STACK];
    logic [7:0]  sym_level  [STACK];
    int          sym_count;
    logic [7:0]  shadow_depth;

    rsp_t        pending_rsp[$];
    logic [15:0] key_pool [8];

    int fail_count;
    int beats_sent;
    int burst_left;
    int op_count [4];
    int hit_count, full_count, underflow_count, saturate_count, deepest;

    // receiver stall pattern
    int  rx_mode, rx_mode_left, rx_stall_left;
    logic rx_next;

    dir_row_t directed [N_DIRECTED] = '{
        '{OP_EXIT,    16'h1357, 16'h2468, 5'd3,  32'hFFFF_FFFF, 1'b1,
          '{1'b0, 16'h0000, ST_UNDERFLOW, 8'd0}},
        '{OP_LOOKUP,  16'h0000, 16'h0000, 5'd0,  32'hFFFF_FFFF, 1'b1,
          '{1'b0, 16'h0000, ST_OK, 8'd0}},
        '{OP_DECLARE, 16'hFFFF, 16'hFFFF, 5'd31, 32'h0000_0000, 1'b1,
          '{1'b0, 16'h0000, ST_OK, 8'd0}},
        '{OP_LOOKUP,  16'hFFFF, 16'h0000, 5'd0,  32'h8000_0000, 1'b1,
          '{1'b1, 16'hFFFF, ST_OK, 8'd0}},
        '{OP_LOOKUP,  16'hFFFF, 16'h0000, 5'd0,  32'h7FFF_FFFF, 1'b1,
          '{1'b0, 16'h0000, ST_OK, 8'd0}},
        '{OP_ENTER,   16'hFFFF, 16'hFFFF, 5'd31, 32'hFFFF_FFFF, 1'b1,
          '{1'b0, 16'h0000, ST_OK, 8'd1}},
        '{OP_DECLARE, 16'h0000, 16'h0000, 5'd0,  32'h0000_0000, 1'b1,
          '{1'b0, 16'h0000, ST_OK, 8'd1}},
        '{OP_DECLARE, 16'hFFFF, 16'h1234, 5'd0,  32'hFFFF_FFFF, 1'b1,
          '{1'b0, 16'h0000, ST_OK, 8'd1}},
        '{OP_LOOKUP,  16'hFFFF, 16'h0000, 5'd0,  32'hFFFF_FFFF, 1'b1,
          '{1'b1, 16'h1234, ST_OK, 8'd1}},
        '{OP_LOOKUP,  16'hFFFF, 16'h0000, 5'd0,  32'h8000_0000, 1'b1,
          '{1'b1, 16'hFFFF, ST_OK, 8'd1}},
        '{OP_LOOKUP,  16'h0000, 16'hFFFF, 5'd31, 32'h0000_0001, 1'b1,
          '{1'b1, 16'h0000, ST_OK, 8'd1}},
        '{OP_LOOKUP,  16'h0000, 16'h0000, 5'd0,  32'h0000_0000, 1'b1,
          '{1'b0, 16'h0000, ST_OK, 8'd1}},
        '{OP_ENTER,   16'h0000, 16'h0000, 5'd0,  32'h0000_0000, 1'b1,
          '{1'b0, 16'h0000, ST_OK, 8'd2}},
        '{OP_DECLARE, 16'h00A5, 16'h5A5A, 5'd16, 32'h0000_0000, 1'b0, '0},
        '{OP_LOOKUP,  16'h00A5, 16'h0000, 5'd0,  32'h0001_0000, 1'b0, '0},
        '{OP_DECLARE, 16'h00A5, 16'hA5A5, 5'd21, 32'h0000_0000, 1'b0, '0},
        '{OP_LOOKUP,  16'h00A5, 16'h0000, 5'd0,  32'hFFFF_FFFF, 1'b0, '0},
        '{OP_EXIT,    16'h00A5, 16'h0000, 5'd0,  32'h0000_0000, 1'b1,
          '{1'b0, 16'h0000, ST_OK, 8'd1}},
        '{OP_LOOKUP,  16'h00A5, 16'h0000, 5'd0,  32'hFFFF_FFFF, 1'b1,
          '{1'b0, 16'h0000, ST_OK, 8'd1}},
        '{OP_EXIT,    16'h0000, 16'h0000, 5'd0,  32'h0000_0000, 1'b1,
          '{1'b0, 16'h0000, ST_OK, 8'd0}},
        '{OP_LOOKUP,  16'hFFFF, 16'h0000, 5'd0,  32'hFFFF_FFFF, 1'b1,
          '{1'b1, 16'hFFFF, ST_OK, 8'd0}},
        '{OP_EXIT,    16'h0000, 16'h0000, 5'd0,  32'h0000_0000, 1'b1,
          '{1'b0, 16'h0000, ST_UNDERFLOW, 8'd0}}
    };

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Applies one accepted beat to the shadow table and returns its result.
    function automatic rsp_t symtab_apply(input req_t r);
        rsp_t o;
        o = '0;
        o.status = ST_OK;
        case (op_t'(r.operation))
            OP_ENTER:
                if (shadow_depth == TOP_LEVEL[7:0])
                    o.status = ST_SATURATED;
                else
                    shadow_depth = shadow_depth + 8'd1;
            OP_EXIT:
                if (shadow_depth == 8'd0)
                    o.status = ST_UNDERFLOW;
                else
                begin
                    shadow_depth = shadow_depth - 8'd1;
                    while (sym_count > 0 && sym_level[sym_count - 1] > shadow_depth)
                        sym_count--;
                end
            OP_DECLARE:
                if (sym_count >= STACK)
                    o.status = ST_FULL;
                else
                begin
                    sym_key[sym_count]    = r.name_key;
                    sym_handle[sym_count] = r.decl_handle;
                    sym_form[sym_count]   = r.decl_form;
                    sym_level[sym_count]  = shadow_depth;
                    sym_count++;
                end
            default:
                // newest entry first
                for (int i = sym_count - 1; i >= 0; i--)
                begin
                    if (!o.found && r.form_mask[sym_form[i]] && sym_key[i] == r.name_key)
                    begin
                        o.found        = 1'b1;
                        o.match_handle = sym_handle[i];
                    end
                end
        endcase
        o.current_level = shadow_depth;
        return o;
    endfunction

    function automatic logic [15:0] pick_key();
        if ($urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, 7)];
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] pick_mask();
        case ($urandom_range(0, 4))
            0: return 32'hFFFF_FFFF;
            1: return 32'd1 << $urandom_range(0, 31);
            2: return ~(32'd1 << $urandom_range(0, 31));
            3: return $urandom;
            default: return $urandom & $urandom;
        endcase
    endfunction

    function automatic req_t make_req(input op_t op);
        req_t r;
        r.operation   = op;
        r.name_key    = pick_key();
        r.decl_handle = 16'($urandom);
        r.decl_form   = 5'($urandom_range(0, 31));
        r.form_mask   = pick_mask();
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        fail_count++;
    endtask

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            req_ch.data  <= req_t'({$urandom, $urandom, $urandom});
        end
    endtask

    // Paces the sender in bursts, drives one beat and records its result.
    task automatic send_beat(input req_t r, input logic typed, input rsp_t want);
        rsp_t predicted;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 16);
            idle_cycles($urandom_range(0, 6));
        end
        burst_left--;
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = symtab_apply(r);
        pending_rsp.push_back(typed ? want : predicted);
        beats_sent++;
        op_count[r.operation]++;
        if (predicted.found)
            hit_count++;
        case (status_t'(predicted.status))
            ST_FULL:      full_count++;
            ST_UNDERFLOW: underflow_count++;
            ST_SATURATED: saturate_count++;
            default: ;
        endcase
        if (shadow_depth > deepest)
            deepest = shadow_depth;
    endtask

    task automatic send_op(input op_t op);
        send_beat(make_req(op), 1'b0, '0);
    endtask

    task automatic run_mix(input int n);
        int pick;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 18)
                send_op(OP_ENTER);
            else if (pick < 36)
                send_op(OP_EXIT);
            else if (pick < 66)
                send_op(OP_DECLARE);
            else
                send_op(OP_LOOKUP);
        end
    endtask

    // declare until the stack is full, push a few more into the wall, then look up
    task automatic run_fill();
        while (sym_count < STACK)
            send_op(($urandom_range(0, 3) == 0) ? OP_LOOKUP : OP_DECLARE);
        repeat ($urandom_range(1, 3))
            send_op(OP_DECLARE);
        repeat ($urandom_range(2, 5))
            send_op(OP_LOOKUP);
    endtask

    // climb to the top scope level, hit saturation, unwind to zero, then underflow
    task automatic run_climb();
        int pick;
        while (shadow_depth != TOP_LEVEL[7:0])
        begin
            pick = $urandom_range(0, 99);
            send_op((pick < 88) ? OP_ENTER : (pick < 94) ? OP_DECLARE : OP_LOOKUP);
        end
        repeat ($urandom_range(1, 3))
            send_op(OP_ENTER);
        send_op(OP_LOOKUP);
        while (shadow_depth != 8'd0)
            send_op(($urandom_range(0, 9) == 0) ? OP_LOOKUP : OP_EXIT);
        send_op(OP_EXIT);
    endtask

    // result monitor
    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.data;
            if (pending_rsp.size() == 0)
            begin
                $display("[%0t] result beat with nothing expected", $time);
                fail_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (got.found !== want.found)
                    report_mismatch("found", want.found, got.found);
                if (got.match_handle !== want.match_handle)
                    report_mismatch("match_handle", want.match_handle, got.match_handle);
                if (got.status !== want.status)
                    report_mismatch("status", want.status, got.status);
                if (got.current_level !== want.current_level)
                    report_mismatch("current_level", want.current_level, got.current_level);
            end
        end
    end

    // receiver: switches between stall patterns every so often
    always @(negedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(20, 200);
        end
        rx_mode_left--;
        case (rx_mode)
            0: rx_next = 1'b1;
            1: rx_next = ($urandom_range(0, 3) != 0);
            2: rx_next = ($urandom_range(0, 3) == 0);
            default:
                if (rx_stall_left > 0)
                begin
                    rx_stall_left--;
                    rx_next = 1'b0;
                end
                else
                begin
                    rx_next = 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        rx_stall_left = $urandom_range(1, 12);
                end
        endcase
        rsp_ch.ready <= rx_next;
    end

    initial
    begin
        #2_000_000;
        $display("[%0t] timeout", $time);
        $display("scoped_symbol_stack test failed");
        $finish;
    end

    initial
    begin
        bit climbed;
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.data   = '0;
        sym_count     = 0;
        shadow_depth  = 8'd0;
        fail_count    = 0;
        beats_sent    = 0;
        burst_left    = 0;
        hit_count     = 0;
        full_count    = 0;
        underflow_count = 0;
        saturate_count  = 0;
        deepest       = 0;
        climbed       = 1'b0;
        foreach (op_count[i])
            op_count[i] = 0;
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        for (int i = 2; i < 8; i++)
            key_pool[i] = 16'($urandom);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_beat('{directed[i].op, directed[i].key, directed[i].handle,
                        directed[i].form, directed[i].mask},
                      directed[i].typed, directed[i].want);

        while (beats_sent < N_DIRECTED + RANDOM_BEATS)
        begin
            if (!climbed && beats_sent >= N_DIRECTED + 150)
            begin
                run_climb();
                climbed = 1'b1;
            end
            else if ($urandom_range(0, 4) == 0)
                run_fill();
            else
                run_mix($urandom_range(10, 40));
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        // lookups take the whole row to scan; allow that for stray beats
        repeat (STACK + 8) @(posedge clk);

        $display("covered %0d beats: %0d enter, %0d exit, %0d declare, %0d lookup",
                 beats_sent, op_count[OP_ENTER], op_count[OP_EXIT],
                 op_count[OP_DECLARE], op_count[OP_LOOKUP]);
        $display("%0d lookup hits, %0d full refusals, %0d underflows, %0d saturations, top level %0d",
                 hit_count, full_count, underflow_count, saturate_count, deepest);
        if (fail_count == 0)
            $display("scoped_symbol_stack test passed");
        else
            $display("scoped_symbol_stack test failed");
        $finish;
    end

endmodule

FILE: scoped_symbol_stack.f
src/sss_pkg.sv
src/sss_req_if.sv
src/sss_rsp_if.sv
src/sss_cell.sv
src/sss_row.sv
src/scoped_symbol_stack.sv
bench/tb_scoped_symbol_stack.sv
